FILE: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescaper: scan modes,
// controller states, the command and status groups between controller and
// datapath, character codes and code point limits.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // scan mode of the unescaper
   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_ESC,
      MODE_HEX,
      MODE_SURR
   } scan_mode_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,
      ST_EMIT,
      ST_FLUSH
   } ctrl_state_type;

   // what one byte step hands to the output encoder
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_RAW,
      EMIT_CP
   } emit_kind_type;

   typedef struct packed {
      logic accept;
      logic feed;
      logic emit;
      logic flush;
   } dp_cmd_type;

   typedef struct packed {
      logic feed_emits;
      logic feed_done;
      logic emit_last;
      logic item_done;
      logic push_ok;
   } dp_status_type;

   typedef struct packed {
      logic [2:0]      count;
      logic [3:0][7:0] bytes;
   } utf8_seq_type;

   localparam int REPLAY_DEPTH = 6;

   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6e;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_BS_OUT = 8'h08;
   localparam logic [7:0] CHAR_FF_OUT = 8'h0c;
   localparam logic [7:0] CHAR_LF_OUT = 8'h0a;
   localparam logic [7:0] CHAR_CR_OUT = 8'h0d;
   localparam logic [7:0] CHAR_HT_OUT = 8'h09;

   localparam logic [15:0] HIGH_SURR_MIN = 16'hd800;
   localparam logic [15:0] HIGH_SURR_MAX = 16'hdbff;
   localparam logic [15:0] LOW_SURR_MIN  = 16'hdc00;
   localparam logic [15:0] LOW_SURR_MAX  = 16'hdfff;
   localparam logic [15:0] CP_REPLACE    = 16'hfffd;

   localparam logic [20:0] CP_ONE_MAX   = 21'h00007f;
   localparam logic [20:0] CP_TWO_MAX   = 21'h0007ff;
   localparam logic [20:0] CP_THREE_MAX = 21'h00ffff;
   localparam logic [20:0] CP_SUPP_BASE = 21'h010000;

   localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
   localparam logic [7:0] UTF8_LEAD3 = 8'he0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hf0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

endpackage

FILE: rtl/jsu_ctrl.sv
// ----------------------------------------------------------------------------
// jsu_ctrl
// Controller of the unescaper: takes a request, steps the datapath through
// replayed bytes and the request byte, paces the output bytes and closes
// each run with a flush of the held-back byte.
// ----------------------------------------------------------------------------
module jsu_ctrl
   import jsu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            if (status.feed_emits) begin
               state_in = ST_EMIT;
            end else if (status.feed_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_EMIT: begin
            if (status.push_ok && status.emit_last) begin
               state_in = status.item_done ? ST_FLUSH : ST_FEED;
            end
         end
         ST_FLUSH: begin
            if (status.push_ok) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_FEED: begin
            cmd.feed = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.push_ok;
         end
         ST_FLUSH: begin
            cmd.flush = status.push_ok;
         end
      endcase
   end

endmodule

FILE: rtl/jsu_datapath.sv
// ----------------------------------------------------------------------------
// jsu_datapath
// Datapath of the unescaper: scan state, replay buffer, one byte step of the
// escape decoder, UTF-8 encoder, held-back output byte and response register.
// ----------------------------------------------------------------------------
module jsu_datapath
   import jsu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [7:0]    req_tdata,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,
   output logic          rsp_tlast
);

   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      logic [4:0] r;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end else begin
         r = 5'd0;
      end
      return r;
   endfunction

   function automatic utf8_seq_type encode_cp(input logic [20:0] cp);
      utf8_seq_type s;
      s.bytes = '0;
      if (cp <= CP_ONE_MAX) begin
         s.count    = 3'd1;
         s.bytes[0] = cp[7:0];
      end else if (cp <= CP_TWO_MAX) begin
         s.count    = 3'd2;
         s.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
         s.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
      end else if (cp <= CP_THREE_MAX) begin
         s.count    = 3'd3;
         s.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
         s.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
         s.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
      end else begin
         s.count    = 3'd4;
         s.bytes[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
         s.bytes[1] = UTF8_CONT | {2'b00, cp[17:12]};
         s.bytes[2] = UTF8_CONT | {2'b00, cp[11:6]};
         s.bytes[3] = UTF8_CONT | {2'b00, cp[5:0]};
      end
      return s;
   endfunction

   // request and scan state
   logic [7:0]      item_byte_ff;
   logic            item_last_ff;
   logic            item_done_ff, item_done_in;
   scan_mode_type   mode_ff, mode_in;
   logic [15:0]     hex_accum_ff, hex_accum_in;
   logic            hex_ok_ff, hex_ok_in;
   logic [15:0]     high_unit_ff, high_unit_in;
   logic [7:0]      replay_buf_ff [REPLAY_DEPTH];
   logic [2:0]      replay_count_ff, replay_count_in;
   logic [2:0]      queue_len_ff, queue_len_in;
   logic [2:0]      queue_idx_ff, queue_idx_in;

   // output side
   logic [3:0][7:0] emit_bytes_ff, emit_bytes_in;
   logic [2:0]      emit_left_ff, emit_left_in;
   logic [7:0]      pend_byte_ff;
   logic            pend_valid_ff;
   logic [7:0]      rsp_tdata_ff;
   logic            rsp_tlast_ff;
   logic            rsp_tvalid_ff;

   // one byte step
   logic            src_item;
   logic [7:0]      src_byte;
   logic            src_last;
   logic [4:0]      nib;
   logic [15:0]     acc_shift;
   logic            hex_ok_t;
   logic            surr_ok;
   logic            replay;
   logic            buf_wr;
   emit_kind_type   kind;
   logic [20:0]     emit_cp;
   utf8_seq_type    seq;
   logic            push_ok;
   logic            rsp_load;

   assign src_item  = (queue_idx_ff >= queue_len_ff);
   assign src_byte  = src_item ? item_byte_ff : replay_buf_ff[queue_idx_ff];
   assign src_last  = src_item & item_last_ff;
   assign nib       = hex_nibble(src_byte);
   assign acc_shift = {hex_accum_ff[11:0], nib[3:0]};
   assign hex_ok_t  = hex_ok_ff & nib[4];

   always_comb begin
      mode_in         = mode_ff;
      hex_accum_in    = hex_accum_ff;
      hex_ok_in       = hex_ok_ff;
      high_unit_in    = high_unit_ff;
      replay_count_in = replay_count_ff;
      replay          = 1'b0;
      buf_wr          = 1'b0;
      kind            = EMIT_NONE;
      emit_cp         = {13'd0, src_byte};
      surr_ok         = 1'b0;
      unique case (mode_ff)
         MODE_PLAIN: begin
            if (src_byte == CHAR_BSLASH) begin
               if (!src_last) begin
                  mode_in = MODE_ESC;
               end
            end else begin
               kind = EMIT_RAW;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_PLAIN;
            kind    = EMIT_RAW;
            case (src_byte)
               CHAR_B: emit_cp = {13'd0, CHAR_BS_OUT};
               CHAR_F: emit_cp = {13'd0, CHAR_FF_OUT};
               CHAR_N: emit_cp = {13'd0, CHAR_LF_OUT};
               CHAR_R: emit_cp = {13'd0, CHAR_CR_OUT};
               CHAR_T: emit_cp = {13'd0, CHAR_HT_OUT};
               CHAR_U: begin
                  if (!src_last) begin
                     kind            = EMIT_NONE;
                     mode_in         = MODE_HEX;
                     hex_accum_in    = '0;
                     hex_ok_in       = 1'b1;
                     replay_count_in = '0;
                  end
               end
               default: emit_cp = {13'd0, src_byte};
            endcase
         end
         MODE_HEX: begin
            hex_accum_in = acc_shift;
            hex_ok_in    = hex_ok_t;
            if (replay_count_ff >= 3'd3) begin
               mode_in         = MODE_PLAIN;
               replay_count_in = '0;
               if (hex_ok_t && acc_shift >= HIGH_SURR_MIN && acc_shift <= HIGH_SURR_MAX
                   && !src_last) begin
                  mode_in      = MODE_SURR;
                  high_unit_in = acc_shift;
               end else begin
                  kind    = EMIT_CP;
                  emit_cp = {5'd0, hex_ok_t ? acc_shift : CP_REPLACE};
               end
            end else if (src_last) begin
               kind    = EMIT_RAW;
               emit_cp = {13'd0, CHAR_U};
               replay  = 1'b1;
            end else begin
               buf_wr          = 1'b1;
               replay_count_in = replay_count_ff + 3'd1;
            end
         end
         MODE_SURR: begin
            case (replay_count_ff)
               3'd0: surr_ok = (src_byte == CHAR_BSLASH);
               3'd1: begin
                  surr_ok      = (src_byte == CHAR_U);
                  hex_accum_in = '0;
               end
               default: begin
                  surr_ok      = nib[4];
                  hex_accum_in = acc_shift;
               end
            endcase
            if (surr_ok && replay_count_ff >= 3'd5 && acc_shift >= LOW_SURR_MIN
                && acc_shift <= LOW_SURR_MAX) begin
               kind            = EMIT_CP;
               emit_cp         = CP_SUPP_BASE + {1'b0, high_unit_ff[9:0], acc_shift[9:0]};
               mode_in         = MODE_PLAIN;
               replay_count_in = '0;
            end else if (surr_ok && replay_count_ff < 3'd5 && !src_last) begin
               buf_wr          = 1'b1;
               replay_count_in = replay_count_ff + 3'd1;
            end else begin
               kind    = EMIT_CP;
               emit_cp = {5'd0, high_unit_ff};
               replay  = 1'b1;
            end
         end
      endcase
      if (replay) begin
         mode_in         = MODE_PLAIN;
         replay_count_in = '0;
      end
   end

   always_comb begin
      if (kind == EMIT_CP) begin
         seq = encode_cp(emit_cp);
      end else begin
         seq       = '0;
         seq.bytes = {24'd0, emit_cp[7:0]};
         seq.count = (kind == EMIT_RAW) ? 3'd1 : 3'd0;
      end
   end

   always_comb begin
      queue_len_in = queue_len_ff;
      queue_idx_in = queue_idx_ff;
      item_done_in = item_done_ff;
      if (cmd.accept) begin
         item_done_in = 1'b0;
         queue_len_in = '0;
         queue_idx_in = '0;
      end else if (cmd.feed) begin
         if (replay) begin
            queue_len_in = replay_count_ff;
            queue_idx_in = '0;
         end else if (src_item) begin
            item_done_in = 1'b1;
         end else begin
            queue_idx_in = queue_idx_ff + 3'd1;
         end
      end
   end

   always_comb begin
      emit_bytes_in = emit_bytes_ff;
      emit_left_in  = emit_left_ff;
      if (cmd.feed) begin
         emit_bytes_in = seq.bytes;
         emit_left_in  = seq.count;
      end else if (cmd.emit) begin
         emit_bytes_in = {8'd0, emit_bytes_ff[3:1]};
         emit_left_in  = emit_left_ff - 3'd1;
      end
   end

   assign push_ok  = !pend_valid_ff || !rsp_tvalid_ff || rsp_tready;
   assign rsp_load = (cmd.emit || cmd.flush) && pend_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_PLAIN;
         hex_accum_ff    <= '0;
         hex_ok_ff       <= 1'b1;
         high_unit_ff    <= '0;
         replay_count_ff <= '0;
         queue_len_ff    <= '0;
         queue_idx_ff    <= '0;
         item_done_ff    <= 1'b0;
         emit_left_ff    <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         if (cmd.feed) begin
            mode_ff         <= mode_in;
            hex_accum_ff    <= hex_accum_in;
            hex_ok_ff       <= hex_ok_in;
            high_unit_ff    <= high_unit_in;
            replay_count_ff <= replay_count_in;
         end
         queue_len_ff <= queue_len_in;
         queue_idx_ff <= queue_idx_in;
         item_done_ff <= item_done_in;
         emit_left_ff <= emit_left_in;
         if (cmd.emit) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_byte_ff <= req_tdata;
         item_last_ff <= req_tlast;
      end
      if (cmd.feed && buf_wr) begin
         replay_buf_ff[replay_count_ff] <= src_byte;
      end
      emit_bytes_ff <= emit_bytes_in;
      if (cmd.emit) begin
         pend_byte_ff <= emit_bytes_ff[0];
      end
      if (rsp_load) begin
         rsp_tdata_ff <= pend_byte_ff;
         rsp_tlast_ff <= cmd.flush;
      end
   end

   assign status.feed_emits = (seq.count != 3'd0);
   assign status.feed_done  = src_item && !replay;
   assign status.emit_last  = (emit_left_ff == 3'd1);
   assign status.item_done  = item_done_ff;
   assign status.push_ok    = push_ok;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

FILE: rtl/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming unescaper of JSON string content to UTF-8 bytes.
// ----------------------------------------------------------------------------
// The request channel (req_) carries one content byte of a string in tdata,
// and tlast marks the final byte of the string. The response channel (rsp_)
// carries one UTF-8 byte in tdata, and tlast marks the last byte caused by a
// request; a request that causes no byte gives no response.
// One request at a time is in work. A request is taken in idle, then its
// byte and any held escape bytes replayed as text are stepped through the
// escape decoder one at a time, each step's UTF-8 bytes are pushed out one
// by one, and a flush closes the request; a new request is taken only after
// the flush. Each output byte passes the held-back byte register and then
// the response register.
// The last output byte of a request is held back until the request is done,
// so that its tlast is known; a response register decouples the channels.
// A stalled receiver stalls the output steps; the next request is still
// taken while the final byte waits in the response register.
// Reset (synchronous, active high) returns the block to plain text mode with
// both channels empty.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte[7:0]
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte[7:0]
   output logic       rsp_tlast
);

   dp_cmd_type    cmd;
   dp_status_type status;

   jsu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   jsu_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: test/unescape_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unescape_checker
// Watches both channels of the JSON string unescaper. Each accepted request
// is run through a behavioral decoder of the escape syntax, and the UTF-8
// bytes it should produce are queued. Every accepted response byte is
// compared with the oldest queued byte. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module unescape_checker
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte[7:0]
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // out_byte[7:0]
   input  logic       rsp_tlast,
   output int         mismatch_count,
   output int         bytes_pending
);

   localparam int MAX_STEP_BYTES = 8;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } text_byte_type;

   scan_mode_type mode;
   logic [15:0]   unit_accum;
   logic          unit_ok;
   logic [15:0]   pending_high;
   logic [7:0]    held [REPLAY_DEPTH];
   int            held_count;

   text_byte_type expected_utf8[$];
   text_byte_type decode_work[$];
   logic [7:0]    step_bytes [MAX_STEP_BYTES];
   int            step_count;

   function automatic int hex_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
   endfunction

   function automatic void put_byte(logic [7:0] b);
      if (step_count < MAX_STEP_BYTES) begin
         step_bytes[step_count] = b;
         step_count++;
      end
   endfunction

   function automatic void put_code_point(logic [20:0] cp);
      if (cp <= CP_ONE_MAX) begin
         put_byte(cp[7:0]);
      end else if (cp <= CP_TWO_MAX) begin
         put_byte(UTF8_LEAD2 | {3'b000, cp[10:6]});
         put_byte(UTF8_CONT | {2'b00, cp[5:0]});
      end else if (cp <= CP_THREE_MAX) begin
         put_byte(UTF8_LEAD3 | {4'h0, cp[15:12]});
         put_byte(UTF8_CONT | {2'b00, cp[11:6]});
         put_byte(UTF8_CONT | {2'b00, cp[5:0]});
      end else begin
         put_byte(UTF8_LEAD4 | {5'b00000, cp[20:18]});
         put_byte(UTF8_CONT | {2'b00, cp[17:12]});
         put_byte(UTF8_CONT | {2'b00, cp[11:6]});
         put_byte(UTF8_CONT | {2'b00, cp[5:0]});
      end
   endfunction

   // held bytes go back to plain text ahead of the current byte
   function automatic void replay_held(logic [7:0] b, logic last);
      text_byte_type item;
      int n;
      n = held_count;
      mode = MODE_PLAIN;
      held_count = 0;
      item.data = b;
      item.last = last;
      decode_work.push_front(item);
      for (int i = n - 1; i >= 0; i--) begin
         item.data = held[i];
         item.last = 1'b0;
         decode_work.push_front(item);
      end
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic last);
      int         nib;
      int         pos;
      logic       good;
      logic       paired;
      logic [3:0] digit;
      nib = hex_value(b);
      digit = (nib < 0) ? 4'h0 : 4'(nib);
      pos = held_count;
      case (mode)
         MODE_ESC: begin
            mode = MODE_PLAIN;
            case (b)
               CHAR_B: put_byte(CHAR_BS_OUT);
               CHAR_F: put_byte(CHAR_FF_OUT);
               CHAR_N: put_byte(CHAR_LF_OUT);
               CHAR_R: put_byte(CHAR_CR_OUT);
               CHAR_T: put_byte(CHAR_HT_OUT);
               CHAR_U: begin
                  if (last) begin
                     put_byte(CHAR_U);
                  end else begin
                     mode = MODE_HEX;
                     unit_accum = '0;
                     unit_ok = 1'b1;
                     held_count = 0;
                  end
               end
               default: put_byte(b);
            endcase
         end
         MODE_HEX: begin
            if (nib < 0) unit_ok = 1'b0;
            unit_accum = {unit_accum[11:0], digit};
            if (held_count >= 3) begin
               mode = MODE_PLAIN;
               held_count = 0;
               if (unit_ok && unit_accum >= HIGH_SURR_MIN && unit_accum <= HIGH_SURR_MAX
                   && !last) begin
                  mode = MODE_SURR;
                  pending_high = unit_accum;
               end else begin
                  put_code_point(unit_ok ? {5'b0, unit_accum} : {5'b0, CP_REPLACE});
               end
            end else if (last) begin
               put_byte(CHAR_U);
               replay_held(b, 1'b1);
            end else begin
               held[held_count] = b;
               held_count++;
            end
         end
         MODE_SURR: begin
            paired = 1'b0;
            if (pos == 0) begin
               good = (b == CHAR_BSLASH);
            end else if (pos == 1) begin
               good = (b == CHAR_U);
               unit_accum = '0;
            end else begin
               good = (nib >= 0);
               unit_accum = {unit_accum[11:0], digit};
            end
            if (good && pos >= 5) begin
               if (unit_accum >= LOW_SURR_MIN && unit_accum <= LOW_SURR_MAX) begin
                  put_code_point(CP_SUPP_BASE + (21'(pending_high - HIGH_SURR_MIN) << 10)
                                 + 21'(unit_accum - LOW_SURR_MIN));
                  mode = MODE_PLAIN;
                  held_count = 0;
                  paired = 1'b1;
               end else begin
                  good = 1'b0;
               end
            end
            if (!paired) begin
               if (good && !last && pos < REPLAY_DEPTH) begin
                  held[pos] = b;
                  held_count++;
               end else begin
                  put_code_point({5'b0, pending_high});
                  replay_held(b, last);
               end
            end
         end
         default: begin
            mode = MODE_PLAIN;
            if (b == CHAR_BSLASH) begin
               if (!last) mode = MODE_ESC;
            end else begin
               put_byte(b);
            end
         end
      endcase
   endfunction

   function automatic void predict_unescape(logic [7:0] b, logic last);
      text_byte_type item;
      step_count = 0;
      decode_work.delete();
      item.data = b;
      item.last = last;
      decode_work.push_front(item);
      while (decode_work.size() > 0) begin
         item = decode_work.pop_front();
         decode_byte(item.data, item.last);
      end
      for (int i = 0; i < step_count; i++) begin
         item.data = step_bytes[i];
         item.last = (i == step_count - 1);
         expected_utf8.insert(expected_utf8.size(), item);
      end
   endfunction

   always @(posedge clock) begin : monitor
      text_byte_type want;
      if (reset) begin
         mode = MODE_PLAIN;
         unit_accum = '0;
         unit_ok = 1'b1;
         pending_high = '0;
         held_count = 0;
         expected_utf8.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_utf8.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual byte %02h last %0b",
                        $time, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_utf8.pop_front();
               if (rsp_tdata !== want.data) begin
                  $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                           $time, want.data, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: run_last mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) predict_unescape(req_tdata, req_tlast);
      end
      bytes_pending <= expected_utf8.size();
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the JSON string unescaper: a few directed strings, then
// random strings built from plain bytes, simple escapes, \u units, surrogate
// pairs and broken escapes, some cut short. Both channels idle at random;
// the receiver once holds off for a long stretch and the sender waits for all
// responses after the directed strings, once among the random ones and at the
// end. A separate checker predicts and compares.
module testbench
   import jsu_pkg::*;
();

   localparam int CYCLE_LIMIT      = 800000;
   localparam int RANDOM_REQUESTS  = 290;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 20;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;   // in_byte[7:0]
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // out_byte[7:0]
   logic       rsp_tlast;

   int         mismatch_count;
   int         bytes_pending;
   int         cycle_count   = 0;
   int         requests_sent = 0;
   logic       steady_flow   = 1'b0;
   logic       hold_off_req  = 1'b0;
   logic [7:0] text_bytes[$];

   json_string_unescape_utf8 DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   unescape_checker utf8_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void append_byte(input logic [7:0] b);
      text_bytes.insert(text_bytes.size(), b);
   endfunction

   function automatic logic [7:0] hex_digit(logic [3:0] n, logic upper);
      if (n < 10) return "0" + {4'h0, n};
      return (upper ? "A" : "a") + {4'h0, n} - 8'd10;
   endfunction

   function automatic logic [7:0] non_hex_byte();
      case ($urandom_range(0, 4))
         0: return "g";
         1: return "G";
         2: return "x";
         3: return " ";
         default: return 8'($urandom_range(128, 255));
      endcase
   endfunction

   task automatic add_unit(input logic [15:0] value);
      logic upper;
      upper = $urandom_range(0, 1);
      append_byte(CHAR_BSLASH);
      append_byte(CHAR_U);
      for (int i = 3; i >= 0; i--) append_byte(hex_digit(value[i*4 +: 4], upper));
   endtask

   function automatic logic [15:0] random_unit();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 16'h007f));
         1: return 16'($urandom_range(16'h0080, 16'h07ff));
         2: return 16'($urandom_range(16'h0800, 16'hffff));
         3: return 16'($urandom_range(HIGH_SURR_MIN, HIGH_SURR_MAX));
         4: return 16'($urandom_range(LOW_SURR_MIN, LOW_SURR_MAX));
         default: return 16'($urandom_range(0, 16'hffff));
      endcase
   endfunction

   function automatic logic [7:0] escape_letter();
      case ($urandom_range(0, 8))
         0: return CHAR_B;
         1: return CHAR_F;
         2: return CHAR_N;
         3: return CHAR_R;
         4: return CHAR_T;
         5: return "\"";
         6: return "/";
         7: return CHAR_BSLASH;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic build_random_text();
      int pick;
      int bad_pos;
      int keep;
      logic [15:0] value;
      repeat ($urandom_range(1, 6)) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            append_byte(8'($urandom_range(0, 255)));
         end else if (pick < 45) begin
            append_byte(CHAR_BSLASH);
            append_byte(escape_letter());
         end else if (pick < 70) begin
            add_unit(random_unit());
         end else if (pick < 90) begin
            add_unit(16'($urandom_range(HIGH_SURR_MIN, HIGH_SURR_MAX)));
            case ($urandom_range(0, 9))
               0: append_byte(8'($urandom_range(0, 255)));
               1: add_unit(random_unit());
               default: add_unit(16'($urandom_range(LOW_SURR_MIN, LOW_SURR_MAX)));
            endcase
         end else begin
            value = random_unit();
            add_unit(value);
            bad_pos = text_bytes.size() - 1 - $urandom_range(0, 3);
            text_bytes[bad_pos] = non_hex_byte();
         end
      end
      // cut the string short, often in the middle of an escape
      if ($urandom_range(0, 3) == 0 && text_bytes.size() > 1) begin
         keep = $urandom_range(1, text_bytes.size() - 1);
         while (text_bytes.size() > keep) void'(text_bytes.pop_back());
      end
   endtask

   task automatic send_request(input logic [7:0] b, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      gap = steady_flow ? 0 : gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text();
      for (int i = 0; i < text_bytes.size(); i++) begin
         send_request(text_bytes[i], i == text_bytes.size() - 1);
      end
      text_bytes.delete();
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
   endtask

   initial begin : receiver
      int gap;
      @(negedge reset);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = steady_flow ? 0 : gap_length();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin : stimulus
      int   directed_count;
      logic held_done;
      logic paused_done;
      held_done   = 1'b0;
      paused_done = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // byte extremes
      append_byte(8'h00);
      append_byte(8'hff);
      send_text();
      // simple escape
      append_byte(CHAR_BSLASH);
      append_byte(CHAR_N);
      send_text();
      // two-byte code point, then a surrogate pair
      add_unit(16'h00e9);
      add_unit(16'hd83d);
      add_unit(16'hde00);
      send_text();
      // lone trailing backslash
      append_byte(CHAR_BSLASH);
      send_text();
      // short unicode escape at string end
      append_byte(CHAR_BSLASH);
      append_byte(CHAR_U);
      append_byte("4");
      send_text();
      wait_for_results();

      directed_count = requests_sent;
      while (requests_sent < directed_count + RANDOM_REQUESTS) begin
         steady_flow = ($urandom_range(0, 6) == 0);
         if (!held_done && requests_sent > directed_count + 100) begin
            held_done = 1'b1;
            steady_flow = 1'b1;
            hold_off_req = 1'b1;
         end
         if (!paused_done && requests_sent > directed_count + 220) begin
            paused_done = 1'b1;
            wait_for_results();
         end
         build_random_text();
         send_text();
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && bytes_pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/jsu_pkg.sv
rtl/jsu_ctrl.sv
rtl/jsu_datapath.sv
rtl/json_string_unescape_utf8.sv
test/unescape_checker.sv
test/testbench.sv
